>>> design/jlsp_pkg.sv
// Shared types, constants and the logistic table of the joint limit scaled P controller.
package jlsp_pkg;

  localparam int JOINTS = 6;
  localparam logic [2:0] LAST_JOINT = 3'(JOINTS - 1);

  localparam int CFG_DATA_W = 16;
  localparam int MUL_W      = 17;
  localparam int PROD_W     = 2 * MUL_W;

  typedef enum logic [2:0] {
    REG_FIRST_LOW  = 3'd0,
    REG_FIRST_HIGH = 3'd1,
    REG_OTHER_LOW  = 3'd2,
    REG_OTHER_HIGH = 3'd3,
    REG_SHARP_LOW  = 3'd4,
    REG_SHARP_HIGH = 3'd5,
    REG_LOOP_GAIN  = 3'd6,
    REG_STOP_THR   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] first_low;
    logic signed [15:0] first_high;
    logic signed [15:0] other_low;
    logic signed [15:0] other_high;
    logic        [7:0]  sharp_low;
    logic        [7:0]  sharp_high;
    logic        [15:0] loop_gain;
    logic        [14:0] stop_thr;
  } cfg_t;

  // g(x) = 1/(1+exp(x)) in Q0.16 at steps of 0.5 from x = 0 to 12.
  localparam logic [15:0] LOGIT_TAB [25] = '{
    16'd32768, 16'd24743, 16'd17625, 16'd11955, 16'd7812, 16'd4971, 16'd3108,
    16'd1921,  16'd1179,  16'd720,   16'd439,   16'd267,  16'd162,  16'd98,
    16'd60,    16'd36,    16'd22,    16'd13,    16'd8,    16'd5,    16'd3,
    16'd2,     16'd1,     16'd1,     16'd0
  };

  typedef enum logic [11:0] {
    ST_IDLE = 12'b000000000001,
    ST_A_LO = 12'b000000000010,
    ST_D_LO = 12'b000000000100,
    ST_A_HI = 12'b000000001000,
    ST_D_HI = 12'b000000010000,
    ST_SQ   = 12'b000000100000,
    ST_SC   = 12'b000001000000,
    ST_SUM  = 12'b000010000000,
    ST_K    = 12'b000100000000,
    ST_RND  = 12'b001000000000,
    ST_R    = 12'b010000000000,
    ST_OUT  = 12'b100000000000
  } state_t;

endpackage

>>> design/joint_limit_scaled_p_controller.sv
// Top level: sequencer around one shared multiplier for the joint limit scaled P controller.
//
//   channel | direction | handshake         | payload
//   in_     | input     | in_valid/in_ready | joint_index, measured_angle, target_angle
//   out_    | output    | out_valid/out_ready | commanded_angle, sample_complete, target_reached
//   cfg_    | input     | cfg_we            | cfg_index, cfg_wdata
//
// For each item the single multiplier forms nine products one after the other (two
// logistic arguments, two interpolations, the squared error, the three steps of the gain
// chain and the squared threshold), and the result register loads after the last of them.
// Reset (rst_n low at a clock edge) clears the sequencer, the output valid and the error sum.
// A new input beat is taken while a finished result still waits in the output register;
// the sequencer only holds in its last step when that register is still full.
module joint_limit_scaled_p_controller
  import jlsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            in_joint_index,
  input  logic signed [15:0]    in_measured_angle,
  input  logic signed [15:0]    in_target_angle,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [15:0]    out_commanded_angle,
  output logic                  out_sample_complete,
  output logic                  out_target_reached,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg;

  jlsp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  state_t state_r, state_nxt;

  logic [MUL_W-1:0]  mul_a, mul_b;
  logic              mul_en;
  logic [PROD_W-1:0] prod;

  jlsp_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Item registers.
  logic [2:0]         joint_r;
  logic signed [15:0] q_r;
  logic [15:0]        mag_r, dlo_mag_r, dhi_mag_r;
  logic               err_neg_r, dlo_neg_r, dhi_neg_r;
  logic [15:0]        base_r;
  logic               sat_r;
  logic [16:0]        lo_r, hi_r, scale_r, k_r;
  logic [31:0]        sq_r;
  logic [29:0]        thr2_r;
  logic [39:0]        sum_r;

  logic               out_valid_r;
  logic signed [15:0] cmd_r;
  logic               complete_r, reached_r;

  // Input side differences.
  logic signed [15:0] lo_lim, hi_lim;
  logic signed [16:0] err_in, dlo_in, dhi_in;

  always_comb begin
    lo_lim = (in_joint_index == 3'd0) ? cfg.first_low  : cfg.other_low;
    hi_lim = (in_joint_index == 3'd0) ? cfg.first_high : cfg.other_high;
    err_in = 17'(in_target_angle) - 17'(in_measured_angle);
    dlo_in = 17'(lo_lim) - 17'(in_measured_angle);
    dhi_in = 17'(in_measured_angle) - 17'(hi_lim);
  end

  // Table lookup from the logistic argument magnitude held in the product register.
  logic        tab_sat;
  logic [4:0]  tab_idx;
  logic [15:0] tab_base;
  logic [12:0] tab_drop;
  logic [10:0] tab_frac;

  always_comb begin
    tab_sat  = (prod[23:11] >= 13'd24);
    tab_idx  = tab_sat ? 5'd23 : prod[15:11];
    tab_base = LOGIT_TAB[tab_idx];
    tab_drop = 13'(tab_base - LOGIT_TAB[tab_idx + 5'd1]);
    tab_frac = prod[10:0];
  end

  // Interpolation finish: the product register holds drop * frac.
  logic [24:0] interp_sum;
  logic [15:0] g_val;
  logic [16:0] g_pos, g_neg;

  always_comb begin
    interp_sum = {1'b0, prod[23:0]} + 25'd1024;
    g_val      = sat_r ? 16'd0 : base_r - 16'(interp_sum[24:11]);
    g_pos      = {1'b0, g_val};
    g_neg      = 17'd65536 - {1'b0, g_val};
  end

  // Rounded Q16 shifts of the product.
  logic [PROD_W-1:0] prod_rnd;
  logic [16:0]       rnd16;

  always_comb begin
    prod_rnd = prod + PROD_W'(32768);
    rnd16    = prod_rnd[32:16];
  end

  // Sum update and command.
  logic [40:0]        sum_add;
  logic signed [17:0] cmd_wide;
  logic signed [15:0] cmd_sat;
  logic               last_joint, out_go;

  always_comb begin
    sum_add    = {1'b0, sum_r} + {9'd0, sq_r};
    cmd_wide   = err_neg_r ? (18'(q_r) - {1'b0, rnd16}) : (18'(q_r) + {1'b0, rnd16});
    if (cmd_wide[17:15] == 3'b000 || cmd_wide[17:15] == 3'b111) begin
      cmd_sat = cmd_wide[15:0];
    end else begin
      cmd_sat = cmd_wide[17] ? 16'sh8000 : 16'sh7FFF;
    end
    last_joint = (joint_r == LAST_JOINT);
    out_go     = (state_r == ST_OUT) && (!out_valid_r || out_ready);
  end

  // Multiplier operand selection.
  always_comb begin
    mul_en = (state_r != ST_IDLE) && (state_r != ST_OUT);
    unique case (state_r)
      ST_A_LO: begin
        mul_a = {1'b0, dlo_mag_r};
        mul_b = {9'd0, cfg.sharp_low};
      end
      ST_D_LO, ST_D_HI: begin
        mul_a = {4'd0, tab_drop};
        mul_b = {6'd0, tab_frac};
      end
      ST_A_HI: begin
        mul_a = {1'b0, dhi_mag_r};
        mul_b = {9'd0, cfg.sharp_high};
      end
      ST_SQ: begin
        mul_a = {1'b0, mag_r};
        mul_b = {1'b0, mag_r};
      end
      ST_SC: begin
        mul_a = lo_r;
        mul_b = hi_r;
      end
      ST_K: begin
        mul_a = {1'b0, cfg.loop_gain};
        mul_b = scale_r;
      end
      ST_RND: begin
        mul_a = {2'd0, cfg.stop_thr};
        mul_b = {2'd0, cfg.stop_thr};
      end
      ST_R: begin
        mul_a = {1'b0, mag_r};
        mul_b = k_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    unique case (state_r)
      ST_IDLE: state_nxt = in_valid ? ST_A_LO : ST_IDLE;
      ST_A_LO: state_nxt = ST_D_LO;
      ST_D_LO: state_nxt = ST_A_HI;
      ST_A_HI: state_nxt = ST_D_HI;
      ST_D_HI: state_nxt = ST_SQ;
      ST_SQ:   state_nxt = ST_SC;
      ST_SC:   state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_K;
      ST_K:    state_nxt = ST_RND;
      ST_RND:  state_nxt = ST_R;
      ST_R:    state_nxt = ST_OUT;
      ST_OUT:  state_nxt = out_go ? ST_IDLE : ST_OUT;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_SUM) begin
        sum_r <= sum_add[40] ? '1 : sum_add[39:0];
      end else if (out_go && last_joint) begin
        sum_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      joint_r   <= in_joint_index;
      q_r       <= in_measured_angle;
      err_neg_r <= err_in[16];
      mag_r     <= err_in[16] ? 16'(-err_in) : err_in[15:0];
      dlo_neg_r <= dlo_in[16];
      dlo_mag_r <= dlo_in[16] ? 16'(-dlo_in) : dlo_in[15:0];
      dhi_neg_r <= dhi_in[16];
      dhi_mag_r <= dhi_in[16] ? 16'(-dhi_in) : dhi_in[15:0];
    end
    if (state_r == ST_D_LO || state_r == ST_D_HI) begin
      base_r <= tab_base;
      sat_r  <= tab_sat;
    end
    // A negative argument mirrors the table: 1 - g(-x).
    if (state_r == ST_A_HI) begin
      lo_r <= dlo_neg_r ? g_neg : g_pos;
    end
    if (state_r == ST_SQ) begin
      hi_r <= dhi_neg_r ? g_neg : g_pos;
    end
    if (state_r == ST_SC) begin
      sq_r <= prod[31:0];
    end
    if (state_r == ST_SUM) begin
      scale_r <= rnd16;
    end
    if (state_r == ST_RND) begin
      k_r <= rnd16;
    end
    if (state_r == ST_R) begin
      thr2_r <= prod[29:0];
    end
    if (out_go) begin
      cmd_r      <= cmd_sat;
      complete_r <= last_joint;
      reached_r  <= last_joint && (sum_r <= {10'd0, thr2_r});
    end
  end

  assign out_valid           = out_valid_r;
  assign out_commanded_angle = cmd_r;
  assign out_sample_complete = complete_r;
  assign out_target_reached  = reached_r;

  // An input beat always starts the sequencer.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_A_LO))
    else $error("sequencer did not start after an input beat");

  // The error sum is empty after the last joint's result is formed.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_go && last_joint) |=> (sum_r == '0))
    else $error("error sum not cleared after the last joint");

  // Target reached is only reported together with a complete sample.
  a_reach: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_sample_complete) |-> !out_target_reached)
    else $error("target reached flagged on an incomplete sample");

endmodule

>>> design/jlsp_cfg_regs.sv
// Configuration register file with reset values for the joint limit scaled P controller.
module jlsp_cfg_regs
  import jlsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg_o
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_low  <= -16'sd2896;
      cfg_r.first_high <= 16'sd2896;
      cfg_r.other_low  <= -16'sd12861;
      cfg_r.other_high <= 16'sd12861;
      cfg_r.sharp_low  <= 8'd20;
      cfg_r.sharp_high <= 8'd20;
      cfg_r.loop_gain  <= 16'd3277;
      cfg_r.stop_thr   <= 15'd410;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_FIRST_LOW:  cfg_r.first_low  <= cfg_wdata;
        REG_FIRST_HIGH: cfg_r.first_high <= cfg_wdata;
        REG_OTHER_LOW:  cfg_r.other_low  <= cfg_wdata;
        REG_OTHER_HIGH: cfg_r.other_high <= cfg_wdata;
        REG_SHARP_LOW:  cfg_r.sharp_low  <= cfg_wdata[7:0];
        REG_SHARP_HIGH: cfg_r.sharp_high <= cfg_wdata[7:0];
        REG_LOOP_GAIN:  cfg_r.loop_gain  <= cfg_wdata;
        REG_STOP_THR:   cfg_r.stop_thr   <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule

>>> design/jlsp_mul.sv
// Shared unsigned multiplier with a registered product.
module jlsp_mul
  import jlsp_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [MUL_W-1:0]  a_i,
  input  logic [MUL_W-1:0]  b_i,
  output logic [PROD_W-1:0] prod_o
);

  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a_i * b_i;
    end
  end

  assign prod_o = prod_r;

endmodule
